>>> sv/ght_pkg.sv
// Shared types and constants for the generational handle table.
// Holds operation and status codes, controller states and the handle layout.
// No dependencies.
package ght_pkg;

    localparam int ROW_W     = 32;
    localparam int ROW_BIT_W = 5;
    localparam int HANDLE_W  = 31;
    localparam int WORD_W    = 64;
    localparam int GEN_W     = 7;
    localparam int HSLOT_W   = 18;
    localparam int TDATA_W   = ((HANDLE_W + WORD_W + 7) / 8) * 8;

    localparam logic [5:0] MARKER_ALL = 6'h3F;

    typedef enum logic [1:0]
    {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_GET    = 2'd2
    } op_t;

    typedef enum logic [1:0]
    {
        STATUS_OK      = 2'd0,
        STATUS_FULL    = 2'd1,
        STATUS_INVALID = 2'd2
    } status_t;

    typedef enum logic [1:0]
    {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_SCAN
    } fsm_t;

    // Lowest free bit of the row last read from the occupancy map
    typedef struct packed
    {
        logic                 any_free;
        logic [ROW_BIT_W-1:0] first_free;
    } row_status_t;

    function automatic logic [HANDLE_W-1:0] make_handle(
        logic [HSLOT_W-1:0] slot,
        logic [GEN_W-1:0]   gen
    );
        return {gen, MARKER_ALL, slot};
    endfunction

endpackage

>>> sv/ght_slot_store.sv
// Slot store: one synchronous memory holding generation and payload per slot.
// One write port, one read port with a registered read.
// No package dependencies.
module ght_slot_store #(
    parameter int DEPTH   = 1024,
    parameter int ADDR_W  = 10,
    parameter int ENTRY_W = 71
) (
    input  logic               clk,
    input  logic               rd_en,
    input  logic [ADDR_W-1:0]  rd_addr,
    output logic [ENTRY_W-1:0] rd_data,
    input  logic               wr_en,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  logic [ENTRY_W-1:0] wr_data
);

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/ght_occ_map.sv
// Occupancy bitmap: a memory of 32-bit rows, one bit per slot, registered read.
// Finds the lowest free bit of the row just read; bits past the capacity count as taken.
// Depends on ght_pkg.
module ght_occ_map #(
    parameter int NUM_ROWS  = 32,
    parameter int ROW_AW    = 5,
    parameter int LAST_BITS = 32
) (
    input  logic                        clk,
    input  logic                        rd_en,
    input  logic [ROW_AW-1:0]           rd_row,
    output logic [ght_pkg::ROW_W-1:0]   rd_data,
    output ght_pkg::row_status_t        rd_status,
    input  logic                        wr_en,
    input  logic [ROW_AW-1:0]           wr_row,
    input  logic [ght_pkg::ROW_W-1:0]   wr_data
);
    import ght_pkg::*;

    localparam logic [ROW_W-1:0] LAST_MASK = ROW_W'((64'd1 << LAST_BITS) - 64'd1);

    logic [ROW_W-1:0]  mem [NUM_ROWS];
    logic [ROW_W-1:0]  data_reg;
    logic [ROW_AW-1:0] row_reg;
    logic [ROW_W-1:0]  free_vec;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_row] <= wr_data;
        end
        if (rd_en)
        begin
            data_reg <= mem[rd_row];
            row_reg  <= rd_row;
        end
    end

    assign rd_data  = data_reg;
    assign free_vec = ~data_reg & ((row_reg == ROW_AW'(NUM_ROWS - 1)) ? LAST_MASK : '1);

    // Priority encode, lowest bit wins
    always_comb
    begin
        rd_status.any_free   = |free_vec;
        rd_status.first_free = '0;
        for (int i = ROW_W - 1; i >= 0; i--)
        begin
            if (free_vec[i])
            begin
                rd_status.first_free = ROW_BIT_W'(i);
            end
        end
    end

endmodule

>>> sv/generational_handle_table.sv
// Generational handle table. Remove and get: slot store and occupancy map are read, the
// entry is checked in S_CHECK, and the result goes through the result and output registers
// to m_tvalid; a new word is taken only back in S_IDLE. Add from the freed-slot cache: the
// same. Add by search: S_SCAN steps from the hint row past full 32-slot rows, then checks.
// Full table, bad marker or index, unused op: one result per cycle unless the output stalls.
// After reset a clearing pass zeroes generations and occupancy; s_tready stays low meanwhile.
module generational_handle_table #(
    parameter int CAPACITY      = 1024,
    parameter int PAYLOAD_WIDTH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ght_pkg::TDATA_W-1:0]   s_tdata,  // [30:0] handle_in, [94:31] data_in, rest zero
    input  logic [1:0]                    s_tuser,  // [1:0] operation
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ght_pkg::TDATA_W-1:0]   m_tdata,  // [30:0] handle_out, [94:31] data_out, rest zero
    output logic [1:0]                    m_tuser   // [1:0] status
);
    import ght_pkg::*;

    localparam int SLOT_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int NUM_ROWS  = (CAPACITY + ROW_W - 1) / ROW_W;
    localparam int ROW_AW    = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int IDX_W     = ROW_AW + ROW_BIT_W;
    localparam int LAST_BITS = CAPACITY - (NUM_ROWS - 1) * ROW_W;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int ENTRY_W   = GEN_W + PAYLOAD_WIDTH;

    localparam logic [HSLOT_W:0]  IDX_LIMIT = (HSLOT_W + 1)'(CAPACITY);
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(CAPACITY);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(CAPACITY - 1);

    // Registers
    fsm_t                     state_reg, state_next;
    logic [SLOT_W-1:0]        clr_cnt_reg, clr_cnt_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     cache_valid_reg, cache_valid_next;
    logic [SLOT_W-1:0]        cache_slot_reg, cache_slot_next;
    logic [ROW_AW-1:0]        hint_reg, hint_next;
    op_t                      op_reg, op_next;
    logic [GEN_W-1:0]         hgen_reg, hgen_next;
    logic [PAYLOAD_WIDTH-1:0] data_reg, data_next;
    logic [SLOT_W-1:0]        cand_reg, cand_next;
    logic                     res_valid_reg, res_valid_next;
    logic [HANDLE_W-1:0]      res_handle_reg, res_handle_next;
    logic [WORD_W-1:0]        res_data_reg, res_data_next;
    status_t                  res_status_reg, res_status_next;
    logic                     out_valid_reg, out_valid_next;
    logic [HANDLE_W-1:0]      out_handle_reg, out_handle_next;
    logic [WORD_W-1:0]        out_data_reg, out_data_next;
    status_t                  out_status_reg, out_status_next;

    // Input decode
    op_t                      in_op;
    logic [HANDLE_W-1:0]      in_handle;
    logic                     in_hdl_ok;
    logic [SLOT_W-1:0]        in_slot;
    logic                     accept;
    logic                     out_free;
    logic                     full;

    // Slot decomposition
    logic [IDX_W-1:0]         in_wide, cache_wide, cand_wide, clr_wide;
    logic [SLOT_W-1:0]        scan_slot;

    // Memory ports
    logic                     slot_rd_en, slot_wr_en;
    logic [SLOT_W-1:0]        slot_rd_addr, slot_wr_addr;
    logic [ENTRY_W-1:0]       slot_rd_data, slot_wr_data;
    logic                     occ_rd_en, occ_wr_en;
    logic [ROW_AW-1:0]        occ_rd_row, occ_wr_row;
    logic [ROW_W-1:0]         occ_rd_data, occ_wr_data;
    row_status_t              occ_st;

    // Check stage
    logic                     chk_occ;
    logic [GEN_W-1:0]         chk_gen;
    logic [PAYLOAD_WIDTH-1:0] chk_payload;
    logic                     chk_hit;
    logic [ROW_W-1:0]         chk_bit_mask;

    assign in_op     = op_t'(s_tuser);
    assign in_handle = s_tdata[HANDLE_W-1:0];
    assign in_hdl_ok = (|in_handle[23:18]) && ({1'b0, in_handle[HSLOT_W-1:0]} < IDX_LIMIT);
    assign in_slot   = SLOT_W'(in_handle[HSLOT_W-1:0]);
    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE) && (!res_valid_reg || out_free);
    assign accept    = s_tvalid && s_tready;
    assign full      = (count_reg == CNT_FULL);

    assign in_wide    = IDX_W'(in_slot);
    assign cache_wide = IDX_W'(cache_slot_reg);
    assign cand_wide  = IDX_W'(cand_reg);
    assign clr_wide   = IDX_W'(clr_cnt_reg);
    assign scan_slot  = SLOT_W'({hint_reg, occ_st.first_free});

    assign chk_bit_mask = ROW_W'(1) << cand_wide[ROW_BIT_W-1:0];
    assign chk_occ      = |(occ_rd_data & chk_bit_mask);
    assign chk_gen      = slot_rd_data[ENTRY_W-1 -: GEN_W];
    assign chk_payload  = slot_rd_data[PAYLOAD_WIDTH-1:0];
    assign chk_hit      = chk_occ && (chk_gen == hgen_reg);

    ght_slot_store #(
        .DEPTH   (CAPACITY),
        .ADDR_W  (SLOT_W),
        .ENTRY_W (ENTRY_W)
    ) u_slot_store (
        .clk     (clk),
        .rd_en   (slot_rd_en),
        .rd_addr (slot_rd_addr),
        .rd_data (slot_rd_data),
        .wr_en   (slot_wr_en),
        .wr_addr (slot_wr_addr),
        .wr_data (slot_wr_data)
    );

    ght_occ_map #(
        .NUM_ROWS  (NUM_ROWS),
        .ROW_AW    (ROW_AW),
        .LAST_BITS (LAST_BITS)
    ) u_occ_map (
        .clk       (clk),
        .rd_en     (occ_rd_en),
        .rd_row    (occ_rd_row),
        .rd_data   (occ_rd_data),
        .rd_status (occ_st),
        .wr_en     (occ_wr_en),
        .wr_row    (occ_wr_row),
        .wr_data   (occ_wr_data)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == SLOT_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_op) inside
                        OP_ADD:
                        begin
                            if (!full)
                            begin
                                state_next = cache_valid_reg ? S_CHECK : S_SCAN;
                            end
                        end
                        OP_REMOVE, OP_GET:
                        begin
                            if (in_hdl_ok)
                            begin
                                state_next = S_CHECK;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_CHECK:
            begin
                state_next = (op_reg == OP_ADD && chk_occ) ? S_SCAN : S_IDLE;
            end
            S_SCAN:
            begin
                if (occ_st.any_free)
                begin
                    state_next = S_CHECK;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and memory commands
    always_comb
    begin
        clr_cnt_next     = clr_cnt_reg;
        count_next       = count_reg;
        cache_valid_next = cache_valid_reg;
        cache_slot_next  = cache_slot_reg;
        hint_next        = hint_reg;
        op_next          = op_reg;
        hgen_next        = hgen_reg;
        data_next        = data_reg;
        cand_next        = cand_reg;
        res_valid_next   = res_valid_reg;
        res_handle_next  = res_handle_reg;
        res_data_next    = res_data_reg;
        res_status_next  = res_status_reg;
        out_valid_next   = out_valid_reg;
        out_handle_next  = out_handle_reg;
        out_data_next    = out_data_reg;
        out_status_next  = out_status_reg;

        slot_rd_en   = 1'b0;
        slot_rd_addr = cand_reg;
        slot_wr_en   = 1'b0;
        slot_wr_addr = cand_reg;
        slot_wr_data = '0;
        occ_rd_en    = 1'b0;
        occ_rd_row   = hint_reg;
        occ_wr_en    = 1'b0;
        occ_wr_row   = cand_wide[IDX_W-1:ROW_BIT_W];
        occ_wr_data  = occ_rd_data;

        // Move a finished result into the output register
        if (out_free)
        begin
            out_valid_next = res_valid_reg;
            if (res_valid_reg)
            begin
                out_handle_next = res_handle_reg;
                out_data_next   = res_data_reg;
                out_status_next = res_status_reg;
                res_valid_next  = 1'b0;
            end
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                slot_wr_en   = 1'b1;
                slot_wr_addr = clr_cnt_reg;
                slot_wr_data = '0;
                occ_wr_en    = 1'b1;
                occ_wr_row   = clr_wide[IDX_W-1:ROW_BIT_W];
                occ_wr_data  = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next         = in_op;
                    hgen_next       = in_handle[HANDLE_W-1 -: GEN_W];
                    data_next       = s_tdata[HANDLE_W +: PAYLOAD_WIDTH];
                    res_handle_next = '0;
                    res_data_next   = '0;
                    res_status_next = STATUS_OK;
                    unique case (in_op) inside
                        OP_ADD:
                        begin
                            if (full)
                            begin
                                res_status_next = STATUS_FULL;
                                res_valid_next  = 1'b1;
                            end
                            else
                            begin
                                cache_valid_next = 1'b0;
                                occ_rd_en        = 1'b1;
                                if (cache_valid_reg)
                                begin
                                    cand_next    = cache_slot_reg;
                                    occ_rd_row   = cache_wide[IDX_W-1:ROW_BIT_W];
                                    slot_rd_en   = 1'b1;
                                    slot_rd_addr = cache_slot_reg;
                                end
                            end
                        end
                        OP_REMOVE, OP_GET:
                        begin
                            if (in_hdl_ok)
                            begin
                                cand_next    = in_slot;
                                occ_rd_en    = 1'b1;
                                occ_rd_row   = in_wide[IDX_W-1:ROW_BIT_W];
                                slot_rd_en   = 1'b1;
                                slot_rd_addr = in_slot;
                            end
                            else
                            begin
                                res_status_next = STATUS_INVALID;
                                res_valid_next  = 1'b1;
                            end
                        end
                        default:
                        begin
                            res_status_next = STATUS_INVALID;
                            res_valid_next  = 1'b1;
                        end
                    endcase
                end
            end
            S_CHECK:
            begin
                case (op_reg)
                    OP_ADD:
                    begin
                        if (chk_occ)
                        begin
                            // Cached slot taken after all: fall back to the search
                            occ_rd_en = 1'b1;
                        end
                        else
                        begin
                            occ_wr_en       = 1'b1;
                            occ_wr_data     = occ_rd_data | chk_bit_mask;
                            slot_wr_en      = 1'b1;
                            slot_wr_data    = {chk_gen, data_reg};
                            count_next      = count_reg + 1'b1;
                            res_handle_next = make_handle(HSLOT_W'(cand_reg), chk_gen);
                            res_valid_next  = 1'b1;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (chk_hit)
                        begin
                            occ_wr_en        = 1'b1;
                            occ_wr_data      = occ_rd_data & ~chk_bit_mask;
                            slot_wr_en       = 1'b1;
                            slot_wr_data     = {chk_gen + 1'b1, chk_payload};
                            count_next       = count_reg - 1'b1;
                            cache_valid_next = 1'b1;
                            cache_slot_next  = cand_reg;
                            if (cand_wide[IDX_W-1:ROW_BIT_W] < hint_reg)
                            begin
                                hint_next = cand_wide[IDX_W-1:ROW_BIT_W];
                            end
                        end
                        else
                        begin
                            res_status_next = STATUS_INVALID;
                        end
                        res_valid_next = 1'b1;
                    end
                    OP_GET:
                    begin
                        if (chk_hit)
                        begin
                            res_data_next = WORD_W'(chk_payload);
                        end
                        else
                        begin
                            res_status_next = STATUS_INVALID;
                        end
                        res_valid_next = 1'b1;
                    end
                    default:
                    begin
                        res_status_next = STATUS_INVALID;
                        res_valid_next  = 1'b1;
                    end
                endcase
            end
            S_SCAN:
            begin
                occ_rd_en = 1'b1;
                if (occ_st.any_free)
                begin
                    cand_next    = scan_slot;
                    slot_rd_en   = 1'b1;
                    slot_rd_addr = scan_slot;
                end
                else
                begin
                    // Every row below the hint is full: advance past this one
                    hint_next  = hint_reg + 1'b1;
                    occ_rd_row = hint_reg + 1'b1;
                end
            end
            default:
            begin
                clr_cnt_next = clr_cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_cnt_reg     <= '0;
            count_reg       <= '0;
            cache_valid_reg <= 1'b0;
            cache_slot_reg  <= '0;
            hint_reg        <= '0;
            res_valid_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_cnt_reg     <= clr_cnt_next;
            count_reg       <= count_next;
            cache_valid_reg <= cache_valid_next;
            cache_slot_reg  <= cache_slot_next;
            hint_reg        <= hint_next;
            res_valid_reg   <= res_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        hgen_reg       <= hgen_next;
        data_reg       <= data_next;
        cand_reg       <= cand_next;
        res_handle_reg <= res_handle_next;
        res_data_reg   <= res_data_next;
        res_status_reg <= res_status_next;
        out_handle_reg <= out_handle_next;
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'({out_data_reg, out_handle_reg});
    assign m_tuser  = out_status_reg;

    // A slot picked by the search must read back as free
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && occ_st.any_free) |=> (state_reg == S_CHECK && !chk_occ))
        else $error("search picked an occupied slot");

    // The search never runs off the last row while the table is not full
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && !occ_st.any_free) |-> (hint_reg != ROW_AW'(NUM_ROWS - 1)))
        else $error("free-slot search ran past the last row");

    // Nothing enters or leaves during the clearing pass
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> (!s_tready && !m_tvalid && !res_valid_reg))
        else $error("traffic during clearing pass");

endmodule

>>> tb/generational_handle_table_tb.sv
// Self-checking testbench for the generational handle table: directed and random add,
// remove, get and unused-code words, with a shadow slot map that predicts every reply.
// Depends on ght_pkg and generational_handle_table.
module generational_handle_table_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ght_pkg::*;

    localparam int CAPACITY   = 1024;
    localparam int CYCLE_CAP  = 400000;
    localparam int DRAIN_WAIT = 50;
    localparam int MIX_WORDS  = 300;
    localparam int CHURN_RUNS = 140;

    // Operation code with no defined meaning
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct
    {
        logic [HANDLE_W-1:0] handle;
        logic [WORD_W-1:0]   data;
        status_t             status;
    } reply_t;

    // Shadow of the slot map plus the queue of replies it has promised
    class slot_map_shadow;
        bit                  occ[CAPACITY];
        logic [GEN_W-1:0]    gen[CAPACITY];
        logic [WORD_W-1:0]   payload[CAPACITY];
        int                  live_count;
        bit                  cache_valid;
        int                  cache_slot;
        reply_t              pending[$];
        int                  failures;
        int                  n_words;
        int                  n_replies;
        int                  n_ok;
        int                  n_full;
        int                  n_invalid;
        int                  n_wraps;

        function new();
            foreach (occ[i])
            begin
                occ[i] = 1'b0;
                gen[i] = '0;
                payload[i] = '0;
            end
            live_count = 0;
            cache_valid = 1'b0;
            cache_slot = 0;
            failures = 0;
            n_words = 0;
            n_replies = 0;
            n_ok = 0;
            n_full = 0;
            n_invalid = 0;
            n_wraps = 0;
        endfunction

        function void flag(string what);
            failures++;
            if (failures <= 10)
                $display("[%0t] MISMATCH %s", $realtime, what);
        endfunction

        function reply_t note_request(logic [1:0] op, logic [HANDLE_W-1:0] h,
                                      logic [WORD_W-1:0] d);
            reply_t r;
            int     idx;
            bit     found;
            bit     hit;
            r.handle = '0;
            r.data = '0;
            r.status = STATUS_OK;
            idx = int'(h[HSLOT_W-1:0]);
            hit = (h[23:18] != 6'd0) && (idx < CAPACITY) && occ[idx]
                  && (gen[idx] == h[30:24]);
            case (op)
                OP_ADD:
                begin
                    if (live_count >= CAPACITY)
                        r.status = STATUS_FULL;
                    else
                    begin
                        found = 1'b0;
                        if (cache_valid)
                        begin
                            cache_valid = 1'b0;
                            if (!occ[cache_slot])
                            begin
                                idx = cache_slot;
                                found = 1'b1;
                            end
                        end
                        for (int i = 0; i < CAPACITY && !found; i++)
                        begin
                            if (!occ[i])
                            begin
                                idx = i;
                                found = 1'b1;
                            end
                        end
                        if (found)
                        begin
                            occ[idx] = 1'b1;
                            payload[idx] = d;
                            live_count++;
                            r.handle = {gen[idx], MARKER_ALL, HSLOT_W'(idx)};
                        end
                        else
                            r.status = STATUS_FULL;
                    end
                end
                OP_REMOVE:
                begin
                    if (hit)
                    begin
                        occ[idx] = 1'b0;
                        payload[idx] = '0;
                        if (gen[idx] == '1)
                            n_wraps++;
                        gen[idx] = gen[idx] + 1'b1;
                        live_count--;
                        cache_slot = idx;
                        cache_valid = 1'b1;
                    end
                    else
                        r.status = STATUS_INVALID;
                end
                OP_GET:
                begin
                    if (hit)
                        r.data = payload[idx];
                    else
                        r.status = STATUS_INVALID;
                end
                default:
                    r.status = STATUS_INVALID;
            endcase
            case (r.status)
                STATUS_OK:   n_ok++;
                STATUS_FULL: n_full++;
                default:     n_invalid++;
            endcase
            n_words++;
            pending.push_back(r);
            return r;
        endfunction

        function void check_reply(logic [HANDLE_W-1:0] h, logic [WORD_W-1:0] d,
                                  logic [1:0] st);
            reply_t e;
            n_replies++;
            if (pending.size() == 0)
            begin
                flag($sformatf("reply %0d with nothing outstanding: handle %h data %h status %0d",
                               n_replies, h, d, st));
                return;
            end
            e = pending.pop_front();
            if (h !== e.handle || d !== e.data || st !== e.status)
                flag($sformatf("reply %0d: expected handle %h data %h status %0d, got handle %h data %h status %0d",
                               n_replies, e.handle, e.data, e.status, h, d, st));
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata;   // [30:0] handle_in, [94:31] data_in, rest zero
    logic [1:0]         s_tuser;   // [1:0] operation
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;   // [30:0] handle_out, [94:31] data_out, rest zero
    logic [1:0]         m_tuser;   // [1:0] status

    slot_map_shadow      sb = new();
    bit                  calm = 1'b0;
    int                  cycles = 0;
    logic [HANDLE_W-1:0] live[$];
    logic [HANDLE_W-1:0] retired[$];

    generational_handle_table #(
        .CAPACITY      (CAPACITY),
        .PAYLOAD_WIDTH (WORD_W)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycles < CYCLE_CAP)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Timed out after %0d cycles", cycles);
        $display("Verification failed");
        $finish;
    end

    always @(negedge clk)
        m_tready <= calm || ($urandom_range(0, 99) >= 20);

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_reply(m_tdata[HANDLE_W-1:0], m_tdata[HANDLE_W+WORD_W-1:HANDLE_W], m_tuser);
    end

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Mostly live handles, some stale or with an odd marker, the rest noise
    function automatic logic [HANDLE_W-1:0] pick_handle();
        logic [HANDLE_W-1:0] h;
        logic [HANDLE_W-1:0] hl;
        int                  sel;
        sel = $urandom_range(0, 99);
        h = HANDLE_W'($urandom);
        if (live.size() != 0)
        begin
            hl = live[$urandom_range(0, live.size() - 1)];
            if (sel < 65)
                h = hl;
            else if (sel < 75)
                h = {hl[30:24] + GEN_W'($urandom_range(1, 127)), hl[23:0]};
            else if (sel < 85)
                h = {hl[30:24], 6'($urandom_range(1, 63)), hl[17:0]};
        end
        if (sel >= 85 && sel < 90 && retired.size() != 0)
            h = retired[$urandom_range(0, retired.size() - 1)];
        return h;
    endfunction

    // Enter at a falling edge; return at the falling edge after acceptance with tvalid held
    task automatic issue(input logic [1:0] op, input logic [HANDLE_W-1:0] h,
                         input logic [WORD_W-1:0] d, output reply_t r);
        int idx;
        if (!calm)
        begin
            while ($urandom_range(0, 99) < 20)
            begin
                s_tvalid <= 1'b0;
                @(negedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {1'b0, d, h};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        r = sb.note_request(op, h, d);
        if (r.status == STATUS_OK && op == OP_ADD)
            live.push_back(r.handle);
        if (r.status == STATUS_OK && op == OP_REMOVE)
        begin
            // Any nonzero marker names the entry: match on slot and generation only
            idx = -1;
            foreach (live[i])
                if (live[i][30:24] == h[30:24] && live[i][HSLOT_W-1:0] == h[HSLOT_W-1:0])
                    idx = i;
            if (idx >= 0)
                live.delete(idx);
            retired.push_back(h);
            if (retired.size() > 64)
                void'(retired.pop_front());
        end
        @(negedge clk);
    endtask

    task automatic random_word(input int add_pct);
        reply_t r;
        int     sel;
        sel = $urandom_range(0, 99);
        if (sel < add_pct)
            issue(OP_ADD, HANDLE_W'($urandom), rand_word(), r);
        else if (sel < add_pct + (100 - add_pct) / 2)
            issue(OP_REMOVE, pick_handle(), rand_word(), r);
        else if (sel < 95)
            issue(OP_GET, pick_handle(), rand_word(), r);
        else
            issue(OP_UNUSED, pick_handle(), rand_word(), r);
    endtask

    initial
    begin : stimulus
        reply_t              r;
        logic [HANDLE_W-1:0] h_a;
        logic [HANDLE_W-1:0] h_b;
        logic [HANDLE_W-1:0] h_d;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: invalid forms on an empty table, then slot reuse order
        issue(OP_GET, '0, '0, r);
        issue(OP_REMOVE, '1, '0, r);
        issue(OP_UNUSED, '1, '1, r);
        issue(OP_ADD, '0, '0, r);
        h_a = r.handle;
        issue(OP_ADD, '1, '1, r);
        h_b = r.handle;
        issue(OP_GET, h_a, '0, r);
        issue(OP_GET, h_b, '0, r);
        issue(OP_GET, {h_b[30:24], 6'h01, h_b[17:0]}, '0, r);
        issue(OP_GET, {h_b[30:24], 6'h00, h_b[17:0]}, '0, r);
        issue(OP_GET, {GEN_W'(0), MARKER_ALL, HSLOT_W'(CAPACITY)}, '0, r);
        issue(OP_GET, {GEN_W'(0), MARKER_ALL, {HSLOT_W{1'b1}}}, '0, r);
        issue(OP_GET, {GEN_W'(0), MARKER_ALL, HSLOT_W'(5)}, '0, r);
        issue(OP_GET, {h_b[30:24] + 1'b1, h_b[23:0]}, '0, r);
        issue(OP_REMOVE, h_a, '0, r);
        issue(OP_GET, h_a, '0, r);
        issue(OP_REMOVE, h_a, '0, r);
        issue(OP_ADD, '0, 64'h0123_4567_89AB_CDEF, r);
        issue(OP_ADD, '0, rand_word(), r);
        h_d = r.handle;
        issue(OP_REMOVE, h_b, '0, r);
        issue(OP_REMOVE, h_d, '0, r);
        // the cache should hand back the last freed slot, then the lowest free one
        issue(OP_ADD, '0, rand_word(), r);
        issue(OP_ADD, '0, rand_word(), r);
        issue(OP_GET, h_a, '0, r);

        repeat (MIX_WORDS)
            random_word(40);

        // Back-to-back churn on the cached slot, long enough to wrap its generation
        calm = 1'b1;
        repeat (CHURN_RUNS)
        begin
            issue(OP_ADD, '0, rand_word(), r);
            h_a = r.handle;
            issue(OP_REMOVE, h_a, '0, r);
            if ($urandom_range(0, 3) == 0)
                issue(OP_GET, h_a, '0, r);
        end
        calm = 1'b0;

        // Fill to capacity, bounce off the full table, then poke around
        while (live.size() < CAPACITY)
            issue(OP_ADD, HANDLE_W'($urandom), rand_word(), r);
        repeat (5)
            issue(OP_ADD, '0, rand_word(), r);
        repeat (3)
            issue(OP_REMOVE, live[$urandom_range(0, live.size() - 1)], '0, r);
        repeat (4)
            issue(OP_ADD, '0, rand_word(), r);
        repeat (150)
            random_word(0);

        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT)
            @(posedge clk);
        if (sb.pending.size() != 0)
            sb.flag($sformatf("%0d replies never arrived", sb.pending.size()));

        $display("Sent %0d words, checked %0d replies: %0d ok, %0d full, %0d invalid",
                 sb.n_words, sb.n_replies, sb.n_ok, sb.n_full, sb.n_invalid);
        $display("Generation wraps seen: %0d, mismatches: %0d", sb.n_wraps, sb.failures);
        if (sb.failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
